### hw/rtl/pcg32_pkg.sv
// ============================================================================
// PCG32 package
// Shared types and constants for the PCG32 XSH-RR random generator unit.
// ============================================================================
package pcg32_pkg;

    // Request function codes.
    typedef enum logic [1:0] {
        FN_RAW     = 2'd0,
        FN_BOUNDED = 2'd1,
        FN_UNIT    = 2'd2,
        FN_SIGNED  = 2'd3
    } t_func;

    // Payload widths.
    localparam int FUNC_W   = 2;
    localparam int BOUND_W  = 32;
    localparam int WORD_W   = 32;
    localparam int VALUE_W  = 33;
    localparam int STATE_W  = 64;
    localparam int STREAM_W = 63;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM     = 2'd1;

    // LCG multiplier, split into halves for the shared 32x32 multiplier.
    localparam logic [STATE_W-1:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;

    // Serial divider: one dividend bit per step.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Partial product selection for the state multiply.
    typedef enum logic [1:0] {
        MS_LL = 2'd0,
        MS_HL = 2'd1,
        MS_LH = 2'd2
    } t_mul_sel;

    // Divider dividend source.
    typedef enum logic {
        DS_NEG_BOUND = 1'b0,
        DS_WORD      = 1'b1
    } t_div_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     seed_clr;
        logic     seed_add;
        logic     req_load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     word_load;
        logic     acc_load;
        logic     acc_add;
        logic     state_commit;
        logic     div_start;
        t_div_src div_src;
        logic     div_step;
        logic     sign_save;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  bound_zero;
        logic  word_ge_thr;
        logic  cfg_hit;
    } t_dp_sts;

endpackage

### hw/rtl/pcg32_req_if.sv
// ============================================================================
// PCG32 request channel
// Valid/ready channel that carries one generator request per transaction.
// ============================================================================
interface pcg32_req_if;
    logic                          valid;
    logic                          ready;
    logic [pcg32_pkg::FUNC_W-1:0]  func;
    logic [pcg32_pkg::BOUND_W-1:0] bound;

    modport source (output valid, output func, output bound, input ready);
    modport sink   (input valid, input func, input bound, output ready);
endinterface

### hw/rtl/pcg32_rsp_if.sv
// ============================================================================
// PCG32 response channel
// Valid/ready channel that carries one generator result per transaction.
// ============================================================================
interface pcg32_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pcg32_pkg::VALUE_W-1:0] value;
    logic                                 bad_bound;

    modport source (output valid, output value, output bad_bound, input ready);
    modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

### hw/rtl/pcg32_datapath.sv
// ============================================================================
// PCG32 datapath
// Configuration registers, LCG state with a shared 32x32 multiplier,
// XSH-RR permutation, serial remainder unit and the result register.
// ============================================================================
module pcg32_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcg32_pkg::t_dp_cmd                 i_cmd,
    output pcg32_pkg::t_dp_sts                 o_sts,
    input  logic                               i_cfg_we,
    input  logic [pcg32_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcg32_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [pcg32_pkg::FUNC_W-1:0]       i_func,
    input  logic [pcg32_pkg::BOUND_W-1:0]      i_bound,
    output logic signed [pcg32_pkg::VALUE_W-1:0] o_value,
    output logic                               o_bad_bound
);
    import pcg32_pkg::*;

    // XSH-RR output permutation of a 64-bit state.
    function automatic logic [WORD_W-1:0] permute(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  mix;
        logic [WORD_W-1:0]   x;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        mix = s ^ (s >> 18);
        x   = mix[58:27];
        rot = s[63:59];
        dbl = {x, x} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

    logic [STATE_W-1:0]  r_seed_state;
    logic [STREAM_W-1:0] r_stream;
    logic                w_cfg_hit;

    logic [STATE_W-1:0]  r_state;
    logic [STATE_W-1:0]  r_inc;
    logic [STATE_W-1:0]  r_prod;
    logic [STATE_W-1:0]  r_acc;
    logic [WORD_W-1:0]   r_word;
    logic                r_neg;
    t_func               r_func;
    logic [BOUND_W-1:0]  r_bound;
    logic [WORD_W-1:0]   r_rem;
    logic [WORD_W-1:0]   r_dvd;
    logic signed [VALUE_W-1:0] r_value;
    logic                r_bad;

    logic [WORD_W-1:0]   w_mul_a;
    logic [WORD_W-1:0]   w_mul_b;
    logic [STATE_W-1:0]  w_mul_p;
    logic [WORD_W:0]     w_trial;
    logic [WORD_W:0]     w_diff;
    logic                w_fits;
    logic [WORD_W:0]     w_mag;

    // Configuration writes; an index beyond the list is dropped.
    assign w_cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_SEED_STATE) ||
                                    (i_cfg_idx == CFG_STREAM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state <= '0;
            r_stream     <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SEED_STATE) begin
                r_seed_state <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_STREAM) begin
                r_stream <= i_cfg_data[STREAM_W-1:0];
            end
        end
    end

    // Shared multiplier operand selection for the three partial products.
    always_comb begin
        case (i_cmd.mul_sel)
            MS_LL: begin
                w_mul_a = r_state[WORD_W-1:0];
                w_mul_b = LCG_MULT[WORD_W-1:0];
            end
            MS_HL: begin
                w_mul_a = r_state[STATE_W-1:WORD_W];
                w_mul_b = LCG_MULT[WORD_W-1:0];
            end
            MS_LH: begin
                w_mul_a = r_state[WORD_W-1:0];
                w_mul_b = LCG_MULT[STATE_W-1:WORD_W];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // LCG state advance and seeding.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_clr) begin
            r_inc   <= {r_stream, 1'b1};
            r_state <= '0;
        end else if (i_cmd.seed_add) begin
            r_state <= r_state + r_seed_state;
        end else if (i_cmd.state_commit) begin
            r_state <= r_acc + r_inc;
        end

        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MS_LL) begin
                r_prod <= w_mul_p;
            end else begin
                r_prod <= {w_mul_p[WORD_W-1:0], {WORD_W{1'b0}}};
            end
        end

        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end

        // The drawn word is the permutation of the state before the advance.
        if (i_cmd.word_load) begin
            r_word <= permute(r_state);
        end

        if (i_cmd.sign_save) begin
            r_neg <= r_word[0];
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_func  <= t_func'(i_func);
            r_bound <= i_bound;
        end
    end

    // Restoring remainder unit, one dividend bit per step.
    assign w_trial = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_bound};
    assign w_fits  = (w_trial >= {1'b0, r_bound});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            if (i_cmd.div_src == DS_WORD) begin
                r_dvd <= r_word;
            end else begin
                r_dvd <= '0 - r_bound;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? w_diff[WORD_W-1:0] : w_trial[WORD_W-1:0];
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    // Result register.
    assign w_mag = {1'b0, r_word};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_bad <= 1'b0;
            case (r_func)
                FN_BOUNDED: begin
                    if (r_bound == '0) begin
                        r_value <= '0;
                        r_bad   <= 1'b1;
                    end else begin
                        r_value <= {1'b0, r_rem};
                    end
                end
                FN_SIGNED: begin
                    r_value <= r_neg ? ('0 - w_mag) : w_mag;
                end
                default: begin
                    r_value <= w_mag;
                end
            endcase
        end
    end

    // While a threshold is held in the remainder, compare the fresh word to it.
    assign o_sts.func        = r_func;
    assign o_sts.bound_zero  = (r_bound == '0);
    assign o_sts.word_ge_thr = (r_word >= r_rem);
    assign o_sts.cfg_hit     = w_cfg_hit;

    assign o_value     = r_value;
    assign o_bad_bound = r_bad;

endmodule

### hw/rtl/pcg32_controller.sv
// ============================================================================
// PCG32 controller
// Sequences seeding, state advances, rejection sampling and result delivery.
// ============================================================================
module pcg32_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcg32_pkg::t_dp_sts i_sts,
    output pcg32_pkg::t_dp_cmd o_cmd,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready
);
    import pcg32_pkg::*;

    typedef enum logic [11:0] {
        S_SEED_CLR = 12'b0000_0000_0001,
        S_SEED_ADD = 12'b0000_0000_0010,
        S_IDLE     = 12'b0000_0000_0100,
        S_DISPATCH = 12'b0000_0000_1000,
        S_THR      = 12'b0000_0001_0000,
        S_MUL0     = 12'b0000_0010_0000,
        S_MUL1     = 12'b0000_0100_0000,
        S_MUL2     = 12'b0000_1000_0000,
        S_MUL3     = 12'b0001_0000_0000,
        S_COMMIT   = 12'b0010_0000_0000,
        S_MOD      = 12'b0100_0000_0000,
        S_FINISH   = 12'b1000_0000_0000
    } t_state;

    // What the current advance is for.
    typedef enum logic [3:0] {
        PH_SEED1 = 4'b0001,
        PH_SEED2 = 4'b0010,
        PH_SIGN  = 4'b0100,
        PH_REQ   = 4'b1000
    } t_phase;

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;

    assign w_accept = i_req_valid && (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_cmd   = '0;

        case (r_state)
            S_SEED_CLR: begin
                o_cmd.seed_clr = 1'b1;
                n_phase        = PH_SEED1;
                n_state        = S_MUL0;
            end
            S_SEED_ADD: begin
                o_cmd.seed_add = 1'b1;
                n_phase        = PH_SEED2;
                n_state        = S_MUL0;
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.func)
                    FN_BOUNDED: begin
                        if (i_sts.bound_zero) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_src   = DS_NEG_BOUND;
                            n_cnt           = '0;
                            n_state         = S_THR;
                        end
                    end
                    FN_SIGNED: begin
                        n_phase = PH_SIGN;
                        n_state = S_MUL0;
                    end
                    default: begin
                        n_phase = PH_REQ;
                        n_state = S_MUL0;
                    end
                endcase
            end
            S_THR: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_phase = PH_REQ;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MS_LL;
                o_cmd.word_load = 1'b1;
                n_state         = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_HL;
                o_cmd.acc_load = 1'b1;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_LH;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.state_commit = 1'b1;
                case (r_phase)
                    PH_SEED1: begin
                        n_state = S_SEED_ADD;
                    end
                    PH_SEED2: begin
                        n_state = S_IDLE;
                    end
                    PH_SIGN: begin
                        o_cmd.sign_save = 1'b1;
                        n_phase         = PH_REQ;
                        n_state         = S_MUL0;
                    end
                    default: begin
                        if (i_sts.func == FN_BOUNDED) begin
                            // Rejected words are redrawn.
                            if (i_sts.word_ge_thr) begin
                                o_cmd.div_start = 1'b1;
                                o_cmd.div_src   = DS_WORD;
                                n_cnt           = '0;
                                n_state         = S_MOD;
                            end else begin
                                n_state = S_MUL0;
                            end
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                endcase
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_SEED_CLR;
            end
        endcase

        // A configuration write restarts seeding from the new values.
        if (i_sts.cfg_hit) begin
            n_state = S_SEED_CLR;
        end
    end

    // Result valid flag: set on load, cleared when the transaction completes.
    assign n_out_valid = (r_out_valid && !i_rsp_ready) || o_cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SEED_CLR;
            r_phase     <= PH_SEED1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

### hw/rtl/pcg32_random_generator_unit.sv
// ============================================================================
// PCG32 random generator unit
// Requests: accept, dispatch, then LCG advances on the shared
// 32x32 multiplier, then a load of the result register.
// Raw and unit fraction take one advance, signed fraction two, bounded
// one per draw plus two 32-step serial remainders; bound zero goes straight to the result.
// Seeding runs after reset or a configuration write; no requests meanwhile.
// ============================================================================
module pcg32_random_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pcg32_req_if.sink                        i_req,
    pcg32_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [pcg32_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcg32_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pcg32_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    pcg32_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

    // Arithmetic and storage.
    pcg32_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_req.func),
        .i_bound     (i_req.bound),
        .o_value     (o_rsp.value),
        .o_bad_bound (o_rsp.bad_bound)
    );

endmodule
